[src/rrts_pkg.sv]
package rrts_pkg;

   localparam logic [2:0] MODE_TICK     = 3'd0;
   localparam logic [2:0] MODE_ALLOC    = 3'd1;
   localparam logic [2:0] MODE_RUNNABLE = 3'd2;
   localparam logic [2:0] MODE_SLEEP    = 3'd3;
   localparam logic [2:0] MODE_WAKEUP   = 3'd4;
   localparam logic [2:0] MODE_SIGNAL   = 3'd5;
   localparam logic [2:0] MODE_START    = 3'd6;
   localparam logic [2:0] MODE_RESCHED  = 3'd7;

   localparam logic [2:0] ST_FREE   = 3'd0;
   localparam logic [2:0] ST_BUILD  = 3'd1;
   localparam logic [2:0] ST_NEW    = 3'd2;
   localparam logic [2:0] ST_RUN    = 3'd3;
   localparam logic [2:0] ST_SLEEP  = 3'd4;
   localparam logic [2:0] ST_KILLED = 3'd5;

   localparam logic [15:0] TIMESLICE_RESET = 16'd20;
   localparam int unsigned CSR_ADDR_W      = 3;
   localparam logic [0:0]  CSR_TIMESLICE   = 1'b0;

   typedef struct packed {
      logic [2:0]  mode;
      logic [3:0]  slot;
      logic [15:0] pid;
      logic [15:0] map_selector;
      logic [15:0] stack_pointer;
      logic [15:0] event_req;
      logic [3:0]  signal_number;
   } req_type;

   typedef struct packed {
      logic        ok;
      logic [3:0]  task_slot;
      logic        switched;
      logic [15:0] restore_selector;
      logic [15:0] restore_stack;
      logic        kill_request;
      logic [15:0] kill_pid;
      logic        last;
   } rsp_type;

endpackage

[src/rrts_csr.sv]
module rrts_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [rrts_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [31:0]                       pwdata,
   output logic [31:0]                       prdata,
   output logic                              pready,
   output logic [15:0]                       timeslice
);

   logic [15:0] timeslice_ff;
   logic        hit;

   assign hit       = (paddr[2:2] == rrts_pkg::CSR_TIMESLICE);
   assign pready    = 1'b1;
   assign timeslice = timeslice_ff;
   assign prdata    = hit ? {16'd0, timeslice_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         timeslice_ff <= rrts_pkg::TIMESLICE_RESET;
      end else if (psel && penable && pwrite && hit) begin
         timeslice_ff <= pwdata[15:0];
      end
   end

endmodule

[src/round_robin_task_scheduler_top.sv]
// Round robin task scheduler with a task table held in one slot memory.
// Commands enter on req_item when start is high and busy is low. Every
// command gives one final result beat (last high) on rsp_item, marked by
// rsp_strobe for one cycle; a reschedule first gives one beat per task it
// kills (kill_request high, last low). The receiver cannot stall: beats
// are shown once and never held.
// Tick without reschedule, start and reschedule-now answer in the
// cycle after acceptance. Make-runnable and sleep read the slot, then
// write it back in S_RMW. Allocate, signal and wakeup read one slot per
// cycle from the memory; a reschedule reads the current slot and then
// the others. The slot memory has a single read port, and one command
// is in flight at a time.
// Reset frees every slot, clears pending signals, current slot and tick
// count, and sets the timeslice to 20; no clearing pass is needed.
// The timeslice register sits at byte address 0 of the APB port.
module round_robin_task_scheduler_top #(
   parameter int unsigned NUM_SLOTS    = 16,
   parameter int unsigned SIGNAL_COUNT = 16,
   parameter int unsigned KILL_SIGNAL  = 9
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  rrts_pkg::req_type               req_item,
   output logic                            rsp_strobe,
   output rrts_pkg::rsp_type               rsp_item,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [rrts_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]                     pwdata,
   output logic [31:0]                     prdata,
   output logic                            pready
);

   localparam int unsigned SW = $clog2(NUM_SLOTS);
   localparam logic [31:0] KILL_BIT  = (KILL_SIGNAL < SIGNAL_COUNT) ?
                                       (32'd1 << KILL_SIGNAL) : 32'd0;
   localparam logic [31:0] KILL_MASK = (32'd1 << (KILL_SIGNAL + 1)) - 32'd1;
   localparam logic [SW-1:0] LAST_SLOT = SW'(NUM_SLOTS - 1);

   typedef struct packed {
      logic [2:0]              state;
      logic [15:0]             pid;
      logic [15:0]             selector;
      logic [15:0]             stack;
      logic [SIGNAL_COUNT-1:0] pending;
      logic [15:0]             wait_event;
   } slot_rec_type;

   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_CUR  = 5'b00010,
      S_SCAN = 5'b00100,
      S_RMW  = 5'b01000,
      S_FIN  = 5'b10000
   } fsm_type;

   function automatic logic [SW-1:0] next_slot(input logic [SW-1:0] s);
      next_slot = (s == LAST_SLOT) ? '0 : s + SW'(1);
   endfunction

   logic [15:0] timeslice;

   rrts_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready),
      .timeslice (timeslice)
   );

   // slot memory
   slot_rec_type          slot_mem [NUM_SLOTS];
   logic [NUM_SLOTS-1:0]  slot_valid_ff;
   slot_rec_type          rd_raw_ff;
   logic                  rd_valid_ff;
   logic                  rd_en;
   logic [SW-1:0]         rd_addr;
   logic                  we;
   logic [SW-1:0]         waddr;
   slot_rec_type          wdata;
   slot_rec_type          rec;

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_raw_ff   <= slot_mem[rd_addr];
         rd_valid_ff <= slot_valid_ff[rd_addr];
      end
      if (we) begin
         slot_mem[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_valid_ff <= '0;
      end else if (we) begin
         slot_valid_ff[waddr] <= 1'b1;
      end
   end

   // an entry never written reads as a free slot with nothing pending
   always_comb begin
      rec = rd_raw_ff;
      if (!rd_valid_ff) begin
         rec.state   = rrts_pkg::ST_FREE;
         rec.pending = '0;
      end
   end

   fsm_type           fsm_ff, fsm_in;
   rrts_pkg::req_type req_ff, req_in;
   logic [SW-1:0]     eidx_ff, eidx_in;
   logic              elast_ff, elast_in;
   logic              woke_ff, woke_in;
   slot_rec_type      cur_rec_ff, cur_rec_in;
   logic [SW-1:0]     cur_ff, cur_in;
   logic [15:0]       ticks_ff, ticks_in;
   rrts_pkg::rsp_type rsp_ff, rsp_in;
   logic              rsp_strobe_ff, rsp_strobe_in;

   logic              cont;
   logic [SW-1:0]     nxt;
   logic [31:0]       sig_bit;
   logic [31:0]       pend32;
   logic              kill_hit;
   logic              cand;

   assign busy       = (fsm_ff != S_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_ff;
   assign nxt        = next_slot(eidx_ff);
   assign sig_bit    = 32'd1 << req_ff.signal_number;
   assign pend32     = 32'(rec.pending);
   assign kill_hit   = ((pend32 & KILL_MASK) == KILL_BIT) && (KILL_BIT != 32'd0);
   assign cand       = (rec.state == rrts_pkg::ST_RUN) || (rec.state == rrts_pkg::ST_NEW) ||
                       ((rec.state == rrts_pkg::ST_SLEEP) && (rec.pending != '0));

   always_comb begin
      fsm_in        = fsm_ff;
      req_in        = req_ff;
      eidx_in       = eidx_ff;
      elast_in      = elast_ff;
      woke_in       = woke_ff;
      cur_rec_in    = cur_rec_ff;
      cur_in        = cur_ff;
      ticks_in      = ticks_ff;
      rsp_in        = rsp_ff;
      rsp_strobe_in = 1'b0;
      rd_en         = 1'b0;
      rd_addr       = eidx_ff;
      we            = 1'b0;
      waddr         = eidx_ff;
      wdata         = rec;
      cont          = 1'b0;

      unique case (fsm_ff)
         S_IDLE: begin
            if (start) begin
               req_in           = req_item;
               rsp_in           = '0;
               rsp_in.last      = 1'b1;
               rsp_in.task_slot = 4'(cur_ff);
               unique case (req_item.mode) inside
                  rrts_pkg::MODE_TICK: begin
                     if (ticks_ff == 16'd1) begin
                        ticks_in = '0;
                        rd_en    = 1'b1;
                        rd_addr  = cur_ff;
                        fsm_in   = S_CUR;
                     end else begin
                        if (ticks_ff != '0) begin
                           ticks_in = ticks_ff - 16'd1;
                        end
                        rsp_strobe_in = 1'b1;
                     end
                  end
                  rrts_pkg::MODE_ALLOC, rrts_pkg::MODE_WAKEUP,
                  rrts_pkg::MODE_SIGNAL: begin
                     rd_en    = 1'b1;
                     rd_addr  = '0;
                     eidx_in  = '0;
                     elast_in = 1'b0;
                     woke_in  = 1'b0;
                     fsm_in   = S_SCAN;
                  end
                  rrts_pkg::MODE_RUNNABLE, rrts_pkg::MODE_SLEEP: begin
                     if (32'(req_item.slot) >= NUM_SLOTS) begin
                        rsp_in.task_slot = '0;
                        rsp_strobe_in    = 1'b1;
                     end else begin
                        rd_en   = 1'b1;
                        rd_addr = SW'(req_item.slot);
                        eidx_in = SW'(req_item.slot);
                        fsm_in  = S_RMW;
                     end
                  end
                  rrts_pkg::MODE_START: begin
                     ticks_in      = timeslice;
                     rsp_in.ok     = 1'b1;
                     rsp_strobe_in = 1'b1;
                  end
                  default: begin
                     ticks_in      = 16'd1;
                     rsp_in.ok     = 1'b1;
                     rsp_strobe_in = 1'b1;
                  end
               endcase
            end
         end

         S_CUR: begin
            // save the outgoing stack, then scan from the slot after current
            cur_rec_in = rec;
            if ((rec.state == rrts_pkg::ST_RUN) || (rec.state == rrts_pkg::ST_SLEEP)) begin
               cur_rec_in.stack = req_ff.stack_pointer;
               we               = 1'b1;
               waddr            = cur_ff;
               wdata            = cur_rec_in;
            end
            rd_en    = 1'b1;
            rd_addr  = next_slot(cur_ff);
            eidx_in  = next_slot(cur_ff);
            elast_in = (next_slot(next_slot(cur_ff)) == cur_ff);
            fsm_in   = S_SCAN;
         end

         S_SCAN: begin
            rsp_in      = '0;
            rsp_in.last = 1'b1;
            case (req_ff.mode)
               rrts_pkg::MODE_ALLOC: begin
                  if (rec.state == rrts_pkg::ST_FREE) begin
                     we                = 1'b1;
                     wdata.state       = rrts_pkg::ST_BUILD;
                     wdata.pid         = req_ff.pid;
                     wdata.selector    = req_ff.map_selector;
                     wdata.stack       = req_ff.stack_pointer;
                     wdata.pending     = '0;
                     rsp_in.ok         = 1'b1;
                     rsp_in.task_slot  = 4'(eidx_ff);
                     rsp_strobe_in     = 1'b1;
                     fsm_in            = S_IDLE;
                  end else if (elast_ff) begin
                     rsp_strobe_in = 1'b1;
                     fsm_in        = S_IDLE;
                  end else begin
                     cont = 1'b1;
                  end
               end
               rrts_pkg::MODE_WAKEUP: begin
                  if ((rec.state == rrts_pkg::ST_SLEEP) &&
                      (rec.wait_event == req_ff.event_req)) begin
                     we               = 1'b1;
                     wdata.state      = rrts_pkg::ST_RUN;
                     wdata.wait_event = '0;
                     woke_in          = 1'b1;
                  end
                  if (elast_ff) begin
                     rsp_in.ok        = woke_in;
                     rsp_in.task_slot = 4'(cur_ff);
                     rsp_strobe_in    = 1'b1;
                     fsm_in           = S_IDLE;
                  end else begin
                     cont = 1'b1;
                  end
               end
               rrts_pkg::MODE_SIGNAL: begin
                  if ((rec.state != rrts_pkg::ST_FREE) && (rec.pid == req_ff.pid)) begin
                     we               = 1'b1;
                     wdata.pending    = rec.pending | sig_bit[SIGNAL_COUNT-1:0];
                     rsp_in.ok        = 1'b1;
                     rsp_in.task_slot = 4'(eidx_ff);
                     rsp_strobe_in    = 1'b1;
                     fsm_in           = S_IDLE;
                  end else if (elast_ff) begin
                     rsp_strobe_in = 1'b1;
                     fsm_in        = S_IDLE;
                  end else begin
                     cont = 1'b1;
                  end
               end
               default: begin
                  if (cand && kill_hit) begin
                     // report the kill and skip this task
                     we                  = 1'b1;
                     wdata.state         = rrts_pkg::ST_KILLED;
                     rsp_in.last         = 1'b0;
                     rsp_in.kill_request = 1'b1;
                     rsp_in.kill_pid     = rec.pid;
                     rsp_in.task_slot    = 4'(eidx_ff);
                     rsp_strobe_in       = 1'b1;
                     if (elast_ff) begin
                        fsm_in = S_FIN;
                     end else begin
                        cont = 1'b1;
                     end
                  end else if (cand) begin
                     if (rec.state == rrts_pkg::ST_NEW) begin
                        we          = 1'b1;
                        wdata.state = rrts_pkg::ST_RUN;
                     end
                     cur_in                  = eidx_ff;
                     ticks_in                = timeslice;
                     rsp_in.ok               = 1'b1;
                     rsp_in.task_slot        = 4'(eidx_ff);
                     rsp_in.switched         = 1'b1;
                     rsp_in.restore_selector = rec.selector;
                     rsp_in.restore_stack    = rec.stack;
                     rsp_strobe_in           = 1'b1;
                     fsm_in                  = S_IDLE;
                  end else if (elast_ff) begin
                     fsm_in = S_FIN;
                  end else begin
                     cont = 1'b1;
                  end
               end
            endcase
            if (cont) begin
               rd_en   = 1'b1;
               rd_addr = nxt;
               eidx_in = nxt;
               if (req_ff.mode == rrts_pkg::MODE_TICK) begin
                  elast_in = (next_slot(nxt) == cur_ff);
               end else begin
                  elast_in = (nxt == LAST_SLOT);
               end
            end
         end

         S_RMW: begin
            we = 1'b1;
            if (req_ff.mode == rrts_pkg::MODE_RUNNABLE) begin
               wdata.state = rrts_pkg::ST_NEW;
            end else begin
               wdata.state      = rrts_pkg::ST_SLEEP;
               wdata.wait_event = req_ff.event_req;
            end
            rsp_in           = '0;
            rsp_in.last      = 1'b1;
            rsp_in.ok        = 1'b1;
            rsp_in.task_slot = 4'(eidx_ff);
            rsp_strobe_in    = 1'b1;
            fsm_in           = S_IDLE;
         end

         default: begin
            // no candidate: stay on the current task
            ticks_in                = timeslice;
            rsp_in                  = '0;
            rsp_in.last             = 1'b1;
            rsp_in.ok               = 1'b1;
            rsp_in.task_slot        = 4'(cur_ff);
            rsp_in.restore_selector = cur_rec_ff.selector;
            rsp_in.restore_stack    = cur_rec_ff.stack;
            rsp_strobe_in           = 1'b1;
            fsm_in                  = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fsm_ff        <= S_IDLE;
         cur_ff        <= '0;
         ticks_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         fsm_ff        <= fsm_in;
         cur_ff        <= cur_in;
         ticks_ff      <= ticks_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff     <= req_in;
      eidx_ff    <= eidx_in;
      elast_ff   <= elast_in;
      woke_ff    <= woke_in;
      cur_rec_ff <= cur_rec_in;
      rsp_ff     <= rsp_in;
   end

endmodule
